// File: rtl/ntc_pkg.sv
package ntc_pkg;

    // sample and table geometry
    localparam int SAMPLE_W     = 12;
    localparam int TABLE_POINTS = 34;
    localparam int SEG_W        = $clog2(TABLE_POINTS);
    localparam int FRAC_BITS    = 8;
    localparam int TEMP_W       = 16;

    // temperature grid
    localparam int STEP_DEG    = 5;
    localparam int FIRST_DEG   = -40;
    localparam int LAST_DEG    = 125;
    localparam int STEP_FIXED  = STEP_DEG << FRAC_BITS;
    localparam int FIRST_FIXED = FIRST_DEG * (1 << FRAC_BITS);
    localparam int LAST_FIXED  = LAST_DEG * (1 << FRAC_BITS);

    // quotient stays below STEP_FIXED, numerator is offset times STEP_FIXED
    localparam int QUOT_W = $clog2(STEP_FIXED);
    localparam int NUM_W  = SAMPLE_W + QUOT_W;

    typedef enum logic [1:0] {
        RS_INTERP = 2'd0,
        RS_BELOW  = 2'd1,
        RS_ABOVE  = 2'd2
    } t_range_status;

    // data that rides along with the divider
    typedef struct packed {
        logic [TEMP_W-1:0] base;
        t_range_status     status;
    } t_side;

    // calibration points, ascending converter codes
    localparam logic [SAMPLE_W-1:0] ADC12_POINTS [TABLE_POINTS] = '{
        12'd199,  12'd259,  12'd332,  12'd420,  12'd523,  12'd643,  12'd780,
        12'd933,  12'd1100, 12'd1279, 12'd1466, 12'd1660, 12'd1855, 12'd2048,
        12'd2236, 12'd2416, 12'd2586, 12'd2745, 12'd2892, 12'd3025, 12'd3147,
        12'd3254, 12'd3349, 12'd3434, 12'd3509, 12'd3576, 12'd3634, 12'd3686,
        12'd3732, 12'd3771, 12'd3806, 12'd3837, 12'd3865, 12'd3889
    };

    localparam logic [SAMPLE_W-1:0] ADC10_POINTS [TABLE_POINTS] = '{
        12'd50,  12'd65,  12'd83,  12'd105, 12'd131, 12'd161, 12'd195,
        12'd233, 12'd275, 12'd320, 12'd367, 12'd415, 12'd464, 12'd512,
        12'd559, 12'd604, 12'd647, 12'd686, 12'd723, 12'd757, 12'd787,
        12'd814, 12'd837, 12'd859, 12'd878, 12'd894, 12'd909, 12'd922,
        12'd933, 12'd943, 12'd952, 12'd960, 12'd966, 12'd972
    };

    // table lookup for the selected converter resolution
    function automatic logic [SAMPLE_W-1:0] adc_point(input logic ten_bit,
                                                      input logic [SEG_W-1:0] idx);
        logic [SAMPLE_W-1:0] pt;
        pt = '0;
        if (idx < SEG_W'(TABLE_POINTS)) begin
            pt = ten_bit ? ADC10_POINTS[idx] : ADC12_POINTS[idx];
        end
        return pt;
    endfunction

endpackage

// File: rtl/ntc_div_pipe.sv
module ntc_div_pipe
    import ntc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [SAMPLE_W-1:0] i_den,
    input  t_side               i_side,
    output logic                o_valid,
    output logic [QUOT_W-1:0]   o_quot,
    output t_side               o_side
);

    // stage 0 loads, stages 1..QUOT_W each retire one quotient bit
    logic                r_vld  [QUOT_W+1];
    logic [SAMPLE_W-1:0] r_rem  [QUOT_W+1];
    logic [QUOT_W-1:0]   r_low  [QUOT_W+1];
    logic [QUOT_W-1:0]   r_quot [QUOT_W+1];
    logic [SAMPLE_W-1:0] r_den  [QUOT_W+1];
    t_side               r_side [QUOT_W+1];

    logic [SAMPLE_W-1:0] n_rem  [QUOT_W+1];
    logic [QUOT_W-1:0]   n_low  [QUOT_W+1];
    logic [QUOT_W-1:0]   n_quot [QUOT_W+1];

    // restoring divide step per stage
    always_comb begin
        logic [SAMPLE_W:0] trial;
        logic              take;
        n_rem[0]  = i_num[NUM_W-1:QUOT_W];
        n_low[0]  = i_num[QUOT_W-1:0];
        n_quot[0] = '0;
        for (int k = 1; k <= QUOT_W; k++) begin
            trial     = {r_rem[k-1], r_low[k-1][QUOT_W-1]};
            take      = (trial >= {1'b0, r_den[k-1]});
            n_rem[k]  = take ? SAMPLE_W'(trial - {1'b0, r_den[k-1]})
                             : trial[SAMPLE_W-1:0];
            n_low[k]  = r_low[k-1] << 1;
            n_quot[k] = {r_quot[k-1][QUOT_W-2:0], take};
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUOT_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= QUOT_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 0; k <= QUOT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_quot[k] <= n_quot[k];
            end
            for (int k = 1; k <= QUOT_W; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[QUOT_W];
    assign o_quot  = r_quot[QUOT_W];
    assign o_side  = r_side[QUOT_W];

endmodule

// File: rtl/ntc_adc_to_temperature_interp.sv
// a sample passes the compare, segment, offset and numerator stages, then the
// restoring divider (the bulk of the depth) and the result register; one sample
// per cycle while not stalled; a stall on the output freezes the whole pipeline,
// nothing is dropped or repeated. reset (synchronous, active low) clears all
// stage valid bits and selects the 12-bit table; there is no clearing pass
module ntc_adc_to_temperature_interp
    import ntc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_ten_bit_mode,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [11:0]              i_adc_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [15:0]       o_temp_q8,
    output logic [1:0]               o_range_status
);

    logic r_ten_bit_mode;
    logic en;

    // stage 1: compares
    logic                    r1_vld;
    logic [SAMPLE_W-1:0]     r1_x;
    logic                    r1_mode;
    logic                    r1_gt0;
    logic [TABLE_POINTS-1:0] r1_ge;
    logic                    n1_gt0;
    logic [TABLE_POINTS-1:0] n1_ge;

    // stage 2: segment
    logic                r2_vld;
    logic [SAMPLE_W-1:0] r2_x;
    logic                r2_mode;
    logic [SEG_W-1:0]    r2_seg;
    t_range_status       r2_status;
    logic [SEG_W-1:0]    n2_seg;
    t_range_status       n2_status;

    // stage 3: offset, span, base
    logic                r3_vld;
    logic [SAMPLE_W-1:0] r3_diff;
    logic [SAMPLE_W-1:0] r3_den;
    t_side               r3_side;
    logic [SAMPLE_W-1:0] n3_diff;
    logic [SAMPLE_W-1:0] n3_den;
    t_side               n3_side;

    // stage 4: scaled numerator
    logic                r4_vld;
    logic [NUM_W-1:0]    r4_num;
    logic [SAMPLE_W-1:0] r4_den;
    t_side               r4_side;

    // divider output and result register
    logic              dv_vld;
    logic [QUOT_W-1:0] dv_quot;
    t_side             dv_side;
    logic              r_out_vld;
    logic [TEMP_W-1:0] r_temp;
    t_range_status     r_status;
    logic [TEMP_W-1:0] n_temp;

    // pipeline advances unless the result is held
    assign en          = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ten_bit_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_ten_bit_mode <= i_cfg_ten_bit_mode;
        end
    end

    // compare sample against every point
    always_comb begin
        n1_gt0 = (i_adc_sample > adc_point(r_ten_bit_mode, '0));
        for (int i = 0; i < TABLE_POINTS; i++) begin
            n1_ge[i] = (i_adc_sample >= adc_point(r_ten_bit_mode, SEG_W'(i)));
        end
    end

    // thermometer to segment index by binary search over inner points
    always_comb begin
        logic [SEG_W-1:0] seg;
        logic [SEG_W-1:0] cand;
        seg = '0;
        for (int b = SEG_W - 1; b >= 0; b--) begin
            cand = seg | (SEG_W'(1) << b);
            if (cand <= SEG_W'(TABLE_POINTS - 2) && r1_ge[cand]) begin
                seg = cand;
            end
        end
        n2_seg = seg;
        if (!r1_gt0) begin
            n2_status = RS_BELOW;
        end else if (r1_ge[TABLE_POINTS-1]) begin
            n2_status = RS_ABOVE;
        end else begin
            n2_status = RS_INTERP;
        end
    end

    // segment endpoints and base temperature
    always_comb begin
        logic [SAMPLE_W-1:0] a0;
        logic [SAMPLE_W-1:0] a1;
        a0      = adc_point(r2_mode, r2_seg);
        a1      = adc_point(r2_mode, r2_seg + SEG_W'(1));
        n3_diff = r2_x - a0;
        n3_den  = a1 - a0;
        n3_side.status = r2_status;
        case (r2_status)
            RS_ABOVE: n3_side.base = TEMP_W'(LAST_FIXED);
            RS_BELOW: n3_side.base = TEMP_W'(FIRST_FIXED);
            default:  n3_side.base = TEMP_W'(FIRST_FIXED)
                                   + TEMP_W'(r2_seg) * TEMP_W'(STEP_FIXED);
        endcase
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_in_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r_out_vld <= dv_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x      <= i_adc_sample;
            r1_mode   <= r_ten_bit_mode;
            r1_gt0    <= n1_gt0;
            r1_ge     <= n1_ge;
            r2_x      <= r1_x;
            r2_mode   <= r1_mode;
            r2_seg    <= n2_seg;
            r2_status <= n2_status;
            r3_diff   <= n3_diff;
            r3_den    <= n3_den;
            r3_side   <= n3_side;
            r4_num    <= NUM_W'(r3_diff) * NUM_W'(STEP_FIXED);
            r4_den    <= r3_den;
            r4_side   <= r3_side;
            r_temp    <= n_temp;
            r_status  <= dv_side.status;
        end
    end

    ntc_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_valid (dv_vld),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    // add the fraction of a step inside the segment
    assign n_temp = (dv_side.status == RS_INTERP)
                  ? dv_side.base + TEMP_W'(dv_quot)
                  : dv_side.base;

    assign o_out_valid    = r_out_vld;
    assign o_temp_q8      = r_temp;
    assign o_range_status = r_status;

    // clamped results carry the end temperatures
    a_below_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_status == RS_BELOW) |-> o_temp_q8 == TEMP_W'(FIRST_FIXED))
        else $error("clamp below gives wrong temperature");

    a_above_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_status == RS_ABOVE) |-> o_temp_q8 == TEMP_W'(LAST_FIXED))
        else $error("clamp above gives wrong temperature");

    // interpolated results stay at or above the first and below the last table temperature
    a_interp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_status == RS_INTERP)
        |-> (o_temp_q8 >= $signed(TEMP_W'(FIRST_FIXED))
             && o_temp_q8 < $signed(TEMP_W'(LAST_FIXED))))
        else $error("interpolated temperature out of range");

    // reset leaves the output not valid right after it
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
